### design/bpq_pkg.sv
// Shared types and constants for the button press / repeat / hold qualifier.
// No dependencies; used by bpq_core and the top level.
package bpq_pkg;

  localparam int SAMPLE_COUNT_DEF = 10;

  localparam logic [3:0]  VOTE_THRESHOLD_RST = 4'd5;
  localparam logic [15:0] REPEAT_DELAY_RST   = 16'd500;
  localparam logic [15:0] HOLD_TIME_RST      = 16'd1200;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_VOTE_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_DELAY   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD_TIME      = 2'd2;

  typedef enum logic [1:0] {
    OP_REFRESH = 2'd0,
    OP_QUERY   = 2'd1,
    OP_HOLD    = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_CONFIRM = 2'd2,
    EV_REFUSE  = 2'd3
  } event_t;

  typedef struct packed {
    logic [3:0]  vote_threshold;
    logic [15:0] repeat_delay_ms;
    logic [15:0] hold_time_ms;
  } cfg_t;

  // One request after voting: opcode, debounced level and timestamp.
  typedef struct packed {
    logic [1:0]  opcode;
    logic        level;
    logic [31:0] time_ms;
  } item_t;

  typedef struct packed {
    event_t ev;
    logic   busy;
  } res_t;

endpackage

### design/bpq_core.sv
// Qualifier state and per-request decision logic: edge press, auto-repeat, long hold.
// Depends on bpq_pkg.
module bpq_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           advance,
  input  bpq_pkg::item_t item,
  input  bpq_pkg::cfg_t  cfg,
  output bpq_pkg::res_t  res
);

  logic        last_level,   last_level_next;
  logic        hold_latched, hold_latched_next;
  logic [31:0] press_stamp,  press_stamp_next;
  logic        hold_waiting, hold_waiting_next;
  logic [31:0] hold_start,   hold_start_next;

  logic [31:0] elapsed;
  logic [31:0] since_press;

  assign elapsed     = item.time_ms - hold_start;
  assign since_press = item.time_ms - press_stamp;

  always_comb begin
    last_level_next   = last_level;
    hold_latched_next = hold_latched;
    press_stamp_next  = press_stamp;
    hold_waiting_next = hold_waiting;
    hold_start_next   = hold_start;
    res.ev            = bpq_pkg::EV_NONE;
    res.busy          = 1'b0;

    if (hold_waiting) begin
      // opcode is ignored while a hold check waits
      if (!item.level || (elapsed >= {16'd0, cfg.hold_time_ms})) begin
        hold_waiting_next = 1'b0;
        last_level_next   = item.level;
        if (item.level) begin
          hold_latched_next = 1'b1;
          res.ev            = bpq_pkg::EV_CONFIRM;
        end else begin
          res.ev = bpq_pkg::EV_REFUSE;
        end
      end else begin
        res.busy = 1'b1;
      end
    end else begin
      unique case (bpq_pkg::opcode_t'(item.opcode))
        bpq_pkg::OP_QUERY: begin
          last_level_next = item.level;
          if (!item.level) begin
            hold_latched_next = 1'b0;
          end
          if (item.level && !last_level) begin
            press_stamp_next = item.time_ms;
            res.ev           = bpq_pkg::EV_PRESS;
          end else if (!hold_latched && item.level && last_level &&
                       (since_press > {16'd0, cfg.repeat_delay_ms})) begin
            res.ev = bpq_pkg::EV_PRESS;
          end
        end
        bpq_pkg::OP_HOLD: begin
          if (!item.level) begin
            res.ev = bpq_pkg::EV_REFUSE;
          end else begin
            hold_waiting_next = 1'b1;
            hold_start_next   = item.time_ms;
            res.busy          = 1'b1;
          end
        end
        default: begin
          // refresh, and the unused code behaves the same
          last_level_next = item.level;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level   <= 1'b0;
      hold_latched <= 1'b0;
      press_stamp  <= '0;
      hold_waiting <= 1'b0;
      hold_start   <= '0;
    end else if (advance) begin
      last_level   <= last_level_next;
      hold_latched <= hold_latched_next;
      press_stamp  <= press_stamp_next;
      hold_waiting <= hold_waiting_next;
      hold_start   <= hold_start_next;
    end
  end

endmodule

### design/button_press_repeat_hold_qualifier_top.sv
// Top level of the button qualifier: config registers, vote, input and result registers.
// Depends on bpq_pkg and bpq_core.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  opcode, sample_bits, time_ms
//   out      source     out_valid/out_stall  event_res, hold_busy
//   cfg      sink       cfg_we               cfg_index, cfg_data
//
// One request per cycle sustained while out_stall is low. The vote goes into
// the input register, the decision into the result register. Reset clears
// the state and loads the register defaults. A stalled result holds the input
// register too, so in_stall follows out_stall while both registers are full.
module button_press_repeat_hold_qualifier_top #(
  parameter int SAMPLE_COUNT = bpq_pkg::SAMPLE_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bpq_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bpq_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     opcode,
  input  logic [SAMPLE_COUNT-1:0]        sample_bits,
  input  logic [31:0]                    time_ms,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     event_res,
  output logic                           hold_busy
);

  localparam int CNT_W = $clog2(SAMPLE_COUNT + 1);
  localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

  bpq_pkg::cfg_t  cfg;
  bpq_pkg::item_t item;
  bpq_pkg::res_t  res;

  logic             item_valid;
  logic             s2_adv;
  logic             s1_adv;
  logic [CNT_W-1:0] high_count;
  logic             level;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.vote_threshold  <= bpq_pkg::VOTE_THRESHOLD_RST;
      cfg.repeat_delay_ms <= bpq_pkg::REPEAT_DELAY_RST;
      cfg.hold_time_ms    <= bpq_pkg::HOLD_TIME_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bpq_pkg::REG_VOTE_THRESHOLD: cfg.vote_threshold  <= cfg_data[3:0];
        bpq_pkg::REG_REPEAT_DELAY:   cfg.repeat_delay_ms <= cfg_data;
        bpq_pkg::REG_HOLD_TIME:      cfg.hold_time_ms    <= cfg_data;
        default: ;
      endcase
    end
  end

  // count high samples
  always_comb begin
    high_count = '0;
    for (int i = 0; i < SAMPLE_COUNT; i++) begin
      high_count = high_count + CNT_W'(sample_bits[i]);
    end
  end

  assign level = CMP_W'(high_count) > CMP_W'(cfg.vote_threshold);

  assign s2_adv   = item_valid && (!out_valid || !out_stall);
  assign s1_adv   = !item_valid || s2_adv;
  assign in_stall = !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s1_adv) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_valid) begin
      item.opcode  <= opcode;
      item.level   <= level;
      item.time_ms <= time_ms;
    end
  end

  bpq_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (s2_adv),
    .item    (item),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      // drop a taken result
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      event_res <= res.ev;
      hold_busy <= res.busy;
    end
  end

endmodule

### bench/bpq_checker.sv
`timescale 1ns / 100ps
// Checker for the button qualifier: tracks register writes, predicts one event per request
// and compares the result channel in order. Depends on bpq_pkg.
module bpq_checker #(
  parameter int SAMPLE_COUNT = bpq_pkg::SAMPLE_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bpq_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bpq_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [1:0]                       opcode,
  input  logic [SAMPLE_COUNT-1:0]          sample_bits,
  input  logic [31:0]                      time_ms,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [1:0]                       event_res,
  input  logic                             hold_busy,
  output int                               fail_count,
  output int                               backlog,
  output int                               compared
);

  logic [3:0]  vote_thr;
  logic [15:0] repeat_ms;
  logic [15:0] hold_ms;

  logic        level_q;
  logic        latched;
  logic        waiting;
  logic [31:0] stamp;
  logic [31:0] hold_t0;

  bpq_pkg::res_t event_q[$];

  function automatic bpq_pkg::res_t qualify(logic [1:0] op, logic [SAMPLE_COUNT-1:0] bits,
                                            logic [31:0] now);
    bpq_pkg::res_t r;
    logic          lvl;
    logic          prev;
    logic [31:0]   elapsed;
    r.ev   = bpq_pkg::EV_NONE;
    r.busy = 1'b0;
    lvl    = $countones(bits) > int'(vote_thr);
    if (waiting) begin
      // the request that ends a wait is the final read of the level
      elapsed = now - hold_t0;
      if (!lvl || elapsed >= {16'd0, hold_ms}) begin
        waiting = 1'b0;
        level_q = lvl;
        if (lvl) begin
          latched = 1'b1;
          r.ev    = bpq_pkg::EV_CONFIRM;
        end else begin
          r.ev = bpq_pkg::EV_REFUSE;
        end
      end else begin
        r.busy = 1'b1;
      end
    end else if (op == bpq_pkg::OP_QUERY) begin
      prev = level_q;
      if (!lvl) latched = 1'b0;
      level_q = lvl;
      elapsed = now - stamp;
      if (lvl && !prev) begin
        stamp = now;
        r.ev  = bpq_pkg::EV_PRESS;
      end else if (!latched && lvl && prev && elapsed > {16'd0, repeat_ms}) begin
        r.ev = bpq_pkg::EV_PRESS;
      end
    end else if (op == bpq_pkg::OP_HOLD) begin
      if (!lvl) begin
        r.ev = bpq_pkg::EV_REFUSE;
      end else begin
        waiting = 1'b1;
        hold_t0 = now;
        r.busy  = 1'b1;
      end
    end else begin
      level_q = lvl;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    bpq_pkg::res_t want;
    if (rst) begin
      vote_thr   = bpq_pkg::VOTE_THRESHOLD_RST;
      repeat_ms  = bpq_pkg::REPEAT_DELAY_RST;
      hold_ms    = bpq_pkg::HOLD_TIME_RST;
      level_q    = 1'b0;
      latched    = 1'b0;
      waiting    = 1'b0;
      stamp      = '0;
      hold_t0    = '0;
      fail_count = 0;
      compared   = 0;
      event_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bpq_pkg::REG_VOTE_THRESHOLD: vote_thr  = cfg_data[3:0];
          bpq_pkg::REG_REPEAT_DELAY:   repeat_ms = cfg_data;
          bpq_pkg::REG_HOLD_TIME:      hold_ms   = cfg_data;
          default: ;
        endcase
      end
      // compare before queueing, so a result never meets its own request
      if (out_valid && !out_stall) begin
        if (event_q.size() == 0) begin
          $error("result with no request outstanding: event_res %0d hold_busy %0d",
                 event_res, hold_busy);
          fail_count++;
        end else begin
          want = event_q.pop_front();
          compared++;
          if (event_res !== want.ev) begin
            $error("event_res: expected %0d, got %0d", want.ev, event_res);
            fail_count++;
          end
          if (hold_busy !== want.busy) begin
            $error("hold_busy: expected %0d, got %0d", want.busy, hold_busy);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) event_q.push_back(qualify(opcode, sample_bits, time_ms));
    end
    backlog = event_q.size();
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// Top of the button qualifier bench: clock, reset, register settings and request stimulus.
// Depends on bpq_pkg, button_press_repeat_hold_qualifier_top and bpq_checker.
module testbench;

  localparam int SAMPLES     = bpq_pkg::SAMPLE_COUNT_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN       = 6;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 325;

  localparam logic [1:0] OP_SPARE = 2'd3;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_we = 1'b0;
  logic [bpq_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [bpq_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [1:0]                      opcode = '0;
  logic [SAMPLES-1:0]              sample_bits = '0;
  logic [31:0]                     time_ms = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [1:0]                      event_res;
  logic                            hold_busy;

  int fail_count;
  int backlog;
  int compared;

  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int sent = 0;
  int settings_used = 1;

  // shadow of the programmed registers, used only to aim the stimulus
  logic [3:0]  thr_now  = bpq_pkg::VOTE_THRESHOLD_RST;
  logic [15:0] rep_now  = bpq_pkg::REPEAT_DELAY_RST;
  logic [15:0] hold_now = bpq_pkg::HOLD_TIME_RST;

  button_press_repeat_hold_qualifier_top dut (.*);
  bpq_checker u_checker (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic logic [SAMPLES-1:0] samples_for(bit pressed);
    logic [SAMPLES-1:0] v;
    int                 k;
    v = '0;
    if (pressed && thr_now < SAMPLES) k = $urandom_range(SAMPLES, thr_now + 1);
    else if (pressed) k = $urandom_range(SAMPLES, 0);
    else k = $urandom_range((thr_now > SAMPLES) ? SAMPLES : thr_now, 0);
    while ($countones(v) < k) v[$urandom_range(SAMPLES - 1)] = 1'b1;
    return v;
  endfunction

  // offset around a delay: one below, on it, one above, or anywhere nearby
  function automatic logic [31:0] near(logic [15:0] span);
    case ($urandom_range(5))
      0:       return (span == 0) ? 32'd0 : 32'(span) - 32'd1;
      1:       return 32'(span);
      2:       return 32'(span) + 32'd1;
      default: return $urandom_range(span + span / 2 + 1, 0);
    endcase
  endfunction

  task automatic send_request(logic [1:0] op, logic [SAMPLES-1:0] bits, logic [31:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    sample_bits <= bits;
    time_ms     <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    while (backlog != 0) @(negedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_settings(logic [3:0] thr, logic [15:0] rep, logic [15:0] hold);
    cfg_we    <= 1'b1;
    cfg_index <= bpq_pkg::REG_VOTE_THRESHOLD;
    cfg_data  <= {12'd0, thr};
    @(posedge clk);
    cfg_index <= bpq_pkg::REG_REPEAT_DELAY;
    cfg_data  <= rep;
    @(posedge clk);
    cfg_index <= bpq_pkg::REG_HOLD_TIME;
    cfg_data  <= hold;
    @(posedge clk);
    cfg_we   <= 1'b0;
    thr_now  = thr;
    rep_now  = rep;
    hold_now = hold;
    settings_used++;
  endtask

  task automatic directed_requests();
    send_request(bpq_pkg::OP_REFRESH, 10'h3FF, 32'd0);
    send_request(bpq_pkg::OP_QUERY,   10'h000, 32'd10);
    send_request(bpq_pkg::OP_QUERY,   10'h03F, 32'd100);       // rising edge, stamp
    send_request(bpq_pkg::OP_QUERY,   10'h3F0, 32'd600);       // exactly the repeat delay
    send_request(bpq_pkg::OP_QUERY,   10'h3FF, 32'd601);       // just past it: repeat
    send_request(bpq_pkg::OP_HOLD,    10'h01F, 32'd700);       // released: refused at once
    send_request(bpq_pkg::OP_HOLD,    10'h3FF, 32'd1000);
    send_request(bpq_pkg::OP_QUERY,   10'h2AA | 10'h001, 32'd2199);
    send_request(bpq_pkg::OP_REFRESH, 10'h3FF, 32'd2200);      // hold time reached
    send_request(bpq_pkg::OP_QUERY,   10'h3FF, 32'd5000);      // latched: no repeat
    send_request(bpq_pkg::OP_QUERY,   10'h000, 32'd5001);      // release clears the latch
    send_request(bpq_pkg::OP_QUERY,   10'h3FF, 32'hFFFF_FF00);
    send_request(bpq_pkg::OP_QUERY,   10'h3FF, 32'h0000_0200); // repeat across the wrap
    send_request(bpq_pkg::OP_HOLD,    10'h3FF, 32'hFFFF_FFF0);
    send_request(bpq_pkg::OP_HOLD,    10'h155, 32'd5);         // release during the wait
    send_request(OP_SPARE,            10'h3FF, 32'd6);
    send_request(OP_SPARE,            10'h000, 32'd7);
    send_request(bpq_pkg::OP_QUERY,   10'h3FF, 32'hFFFF_FFFF);
    send_request(bpq_pkg::OP_HOLD,    10'h3FF, 32'hFFFF_FFFF);
    send_request(OP_SPARE,            10'h3FF, 32'd1198);      // one short of the hold time
    send_request(bpq_pkg::OP_QUERY,   10'h3FF, 32'd1199);      // wrapped elapsed = hold time
    send_request(bpq_pkg::OP_QUERY,   10'h3FF, 32'hAAAA_5555);
    send_request(bpq_pkg::OP_QUERY,   10'h000, 32'h5555_AAAA);
  endtask

  task automatic noise_request();
    logic [SAMPLES-1:0] bits;
    bits = ($urandom_range(1) != 0) ? samples_for(1'($urandom_range(1)))
                                    : SAMPLES'($urandom_range(1023));
    send_request(2'($urandom_range(3)), bits, $urandom);
  endtask

  // lead-in release, press, held queries, optional hold check, more held queries, release
  task automatic press_sequence();
    logic [31:0] t0;
    logic [31:0] h0;
    int          n;
    t0 = ($urandom_range(4) == 0) ? 32'hFFFF_FFFF - $urandom_range(3000) : $urandom;
    send_request(($urandom_range(1) != 0) ? bpq_pkg::OP_REFRESH : bpq_pkg::OP_QUERY,
                 samples_for(0), t0 - $urandom_range(50));
    send_request(bpq_pkg::OP_QUERY, samples_for(1), t0);
    n = $urandom_range(4, 1);
    repeat (n) begin
      send_request(bpq_pkg::OP_QUERY, samples_for($urandom_range(9) != 0), t0 + near(rep_now));
    end
    if ($urandom_range(9) < 7) begin
      h0 = t0 + $urandom_range(rep_now + 10);
      send_request(bpq_pkg::OP_HOLD, samples_for($urandom_range(9) != 0), h0);
      n = $urandom_range(5, 1);
      repeat (n) begin
        send_request(2'($urandom_range(3)), samples_for($urandom_range(19) > 2),
                     h0 + (($urandom_range(1) != 0) ? near(hold_now)
                                                    : $urandom_range(hold_now)));
      end
    end
    n = $urandom_range(3, 1);
    repeat (n) send_request(bpq_pkg::OP_QUERY, samples_for(1), t0 + near(rep_now));
    send_request(bpq_pkg::OP_QUERY, samples_for(0), t0 + $urandom_range(70000));
  endtask

  initial begin
    int phase_start;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < PHASES; phase++) begin
      // idling regime changes every two register settings
      case (phase / 2)
        0: begin send_idle_pct = 7;  recv_stall_pct <= 55; end
        1: begin send_idle_pct = 55; recv_stall_pct <= 7;  end
        default: begin send_idle_pct = 0; recv_stall_pct <= 0; end
      endcase
      case (phase)
        0: ;  // reset values
        1: write_settings(4'd0, 16'd0, 16'd0);
        2: write_settings(4'd10, 16'hFFFF, 16'hFFFF);
        3: write_settings(4'd3, 16'd100, 16'd300);
        4: write_settings(4'($urandom_range(9, 1)), 16'($urandom_range(2000)),
                          16'($urandom_range(3000)));
        default: write_settings(4'd5, 16'd1, 16'd2);
      endcase
      phase_start = sent;
      if (phase == 0) directed_requests();
      while (sent - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(99) < 25) noise_request();
        else press_sequence();
      end
      in_valid <= 1'b0;
      settle();
    end

    $display("summary: %0d requests over %0d register settings, %0d results compared",
             sent, settings_used, compared);
    $display("summary: idling regimes covered sender-heavy, receiver-heavy and none");
    if (fail_count == 0 && backlog == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

### files.f
design/bpq_pkg.sv
design/bpq_core.sv
design/button_press_repeat_hold_qualifier_top.sv
bench/bpq_checker.sv
bench/testbench.sv
